FILE: design/assert_macros.svh
// Assertion helpers shared by the receiver modules.
// Each macro assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/tfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the telemetry frame receiver.
// No dependencies.
package tfr_pkg;

    localparam logic [7:0] SyncByte  = 8'hAA;
    localparam logic [7:0] IdE0      = 8'hE0;
    localparam logic [7:0] IdE1      = 8'hE1;
    localparam logic [7:0] IdE2      = 8'hE2;
    localparam logic [7:0] ZeroByte  = 8'h00;
    localparam logic [7:0] AckLen    = 8'd3;
    localparam logic [7:0] ReplyLen  = 8'd2;

    localparam logic [7:0] DevAddrReset  = 8'hFF;
    localparam logic [7:0] HostAddrReset = 8'hFA;
    localparam logic [7:0] AckIdReset    = 8'h00;

    // configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgDeviceAddr  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgHostAddr    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCheckFrameId = 2'd2;

    // reply word positions: check frame 0..8, optional E2 reply 9..16
    localparam int PosW = 5;
    localparam logic [PosW-1:0] PosAckSync  = 5'd0;
    localparam logic [PosW-1:0] PosAckAddr  = 5'd1;
    localparam logic [PosW-1:0] PosAckId    = 5'd2;
    localparam logic [PosW-1:0] PosAckLen   = 5'd3;
    localparam logic [PosW-1:0] PosAckFid   = 5'd4;
    localparam logic [PosW-1:0] PosAckRsum  = 5'd5;
    localparam logic [PosW-1:0] PosAckRadd  = 5'd6;
    localparam logic [PosW-1:0] PosAckSum   = 5'd7;
    localparam logic [PosW-1:0] PosAckAdd   = 5'd8;
    localparam logic [PosW-1:0] PosRepSync  = 5'd9;
    localparam logic [PosW-1:0] PosRepAddr  = 5'd10;
    localparam logic [PosW-1:0] PosRepId    = 5'd11;
    localparam logic [PosW-1:0] PosRepLen   = 5'd12;
    localparam logic [PosW-1:0] PosRepDev   = 5'd13;
    localparam logic [PosW-1:0] PosRepZero  = 5'd14;
    localparam logic [PosW-1:0] PosRepSum   = 5'd15;
    localparam logic [PosW-1:0] PosRepAdd   = 5'd16;

    // command queue between parser and reply generator
    localparam int QDepth = 2;
    localparam int QPtrW  = 1;
    localparam int QCntW  = 2;

    typedef struct packed {
        logic       err;
        logic       ok;
        logic       e1;
        logic [7:0] rsum;
        logic [7:0] radd;
        logic [7:0] fid;
    } cmd_t;

endpackage

FILE: design/tfr_in_if.sv
`timescale 1ns / 1ps
// Input word channel: one received link byte per word.
// No dependencies.
interface tfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/tfr_out_if.sv
`timescale 1ns / 1ps
// Result word channel: status flags and one reply byte per word.
// No dependencies.
interface tfr_out_if;
    logic       valid;
    logic       ready;
    logic       rx_error;
    logic       frame_ok;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, output rx_error, output frame_ok, output tx_valid,
                    output tx_byte, output last, input ready);
    modport sink   (input valid, input rx_error, input frame_ok, input tx_valid,
                    input tx_byte, input last, output ready);
endinterface

FILE: design/tfr_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on tfr_pkg.
interface tfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tfr_pkg::CfgIdxW-1:0]    index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tfr_front.sv
`timescale 1ns / 1ps
// Frame parser: hunts for sync, checks address, id and both checks.
// Depends on tfr_pkg. Emits one command per accepted byte.
module tfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    input  logic [7:0]          device_addr,
    input  logic                q_full,
    output logic                push,
    output tfr_pkg::cmd_t       cmd
);

    typedef enum logic [6:0] {
        FS_HUNT = 7'b0000001,
        FS_ADDR = 7'b0000010,
        FS_ID   = 7'b0000100,
        FS_LEN  = 7'b0001000,
        FS_PAY  = 7'b0010000,
        FS_SUM  = 7'b0100000,
        FS_ADD  = 7'b1000000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [7:0] fid_reg, fid_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] add_reg, add_next;
    logic [7:0] rsum_reg, rsum_next;

    logic [7:0] sum_take;
    logic [7:0] add_take;
    logic [7:0] cnt_inc;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign sum_take = sum_reg + in_byte;
    assign add_take = add_reg + sum_take;
    assign cnt_inc  = cnt_reg + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        fid_next   = fid_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        add_next   = add_reg;
        rsum_next  = rsum_reg;
        cmd.err    = 1'b0;
        cmd.ok     = 1'b0;
        cmd.e1     = (fid_reg == tfr_pkg::IdE1);
        cmd.fid    = fid_reg;
        cmd.rsum   = rsum_reg;
        cmd.radd   = in_byte;
        case (state_reg)
            FS_ADDR:
            begin
                if (in_byte == device_addr)
                begin
                    sum_next   = sum_take;
                    add_next   = add_take;
                    state_next = FS_ID;
                end
                else
                begin
                    cmd.err    = 1'b1;
                    state_next = FS_HUNT;
                end
            end
            FS_ID:
            begin
                if (in_byte inside {tfr_pkg::IdE0, tfr_pkg::IdE1, tfr_pkg::IdE2})
                begin
                    sum_next   = sum_take;
                    add_next   = add_take;
                    fid_next   = in_byte;
                    state_next = FS_LEN;
                end
                else
                begin
                    cmd.err    = 1'b1;
                    state_next = FS_HUNT;
                end
            end
            FS_LEN:
            begin
                sum_next   = sum_take;
                add_next   = add_take;
                len_next   = in_byte;
                cnt_next   = 8'd0;
                state_next = (in_byte == tfr_pkg::ZeroByte) ? FS_SUM : FS_PAY;
            end
            FS_PAY:
            begin
                sum_next = sum_take;
                add_next = add_take;
                cnt_next = cnt_inc;
                if (cnt_inc == len_reg)
                begin
                    state_next = FS_SUM;
                end
            end
            FS_SUM:
            begin
                rsum_next  = in_byte;
                state_next = FS_ADD;
            end
            FS_ADD:
            begin
                state_next = FS_HUNT;
                if (sum_reg == rsum_reg && add_reg == in_byte)
                begin
                    cmd.ok = 1'b1;
                end
                else
                begin
                    cmd.err = 1'b1;
                end
            end
            default:
            begin
                state_next = FS_HUNT;
                if (in_byte == tfr_pkg::SyncByte)
                begin
                    sum_next   = tfr_pkg::SyncByte;
                    add_next   = tfr_pkg::SyncByte;
                    state_next = FS_ADDR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_HUNT;
            fid_reg   <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            add_reg   <= 8'd0;
            rsum_reg  <= 8'd0;
        end
        else if (push)
        begin
            state_reg <= state_next;
            fid_reg   <= fid_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            add_reg   <= add_next;
            rsum_reg  <= rsum_next;
        end
    end

endmodule

FILE: design/tfr_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between parser and reply generator.
// Depends on tfr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tfr_pkg::cmd_t       push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output tfr_pkg::cmd_t       head_cmd
);

    tfr_pkg::cmd_t q_reg [tfr_pkg::QDepth];
    logic [tfr_pkg::QPtrW-1:0] wr_ptr_reg;
    logic [tfr_pkg::QPtrW-1:0] rd_ptr_reg;
    logic [tfr_pkg::QCntW-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full       = (count_reg == tfr_pkg::QCntW'(tfr_pkg::QDepth));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_q_count_range, count_reg <= tfr_pkg::QCntW'(tfr_pkg::QDepth), "queue overfilled")
    `ASSERT_IMPLIES(a_q_ptr_match, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with skewed pointers")
    `ASSERT_IMPLIES(a_q_pop_head, pop, head_valid, "pop from empty queue")

endmodule

FILE: design/tfr_back.sv
`timescale 1ns / 1ps
// Reply generator: expands each command into its result words.
// Depends on tfr_pkg and assert_macros.svh. Output word is registered.
`include "assert_macros.svh"
module tfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  tfr_pkg::cmd_t       head_cmd,
    output logic                pop,
    input  logic [7:0]          device_addr,
    input  logic [7:0]          host_addr,
    input  logic [7:0]          check_frame_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_rx_error,
    output logic                out_frame_ok,
    output logic                out_tx_valid,
    output logic [7:0]          out_tx_byte,
    output logic                out_last
);

    logic [tfr_pkg::PosW-1:0] pos_reg, pos_next;
    logic [7:0] s_reg, s_next;
    logic [7:0] a_reg, a_next;
    logic       valid_reg;
    logic       err_reg;
    logic       ok_reg;
    logic       txv_reg;
    logic [7:0] txb_reg;
    logic       last_reg;

    logic       load;
    logic [7:0] word_byte;
    logic       word_last;
    logic       data_pos;
    logic       frame_start;
    logic [7:0] s_new;
    logic [7:0] a_new;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && word_last;

    always_comb
    begin
        word_byte = tfr_pkg::ZeroByte;
        data_pos  = 1'b1;
        case (pos_reg)
            tfr_pkg::PosAckSync: word_byte = tfr_pkg::SyncByte;
            tfr_pkg::PosAckAddr: word_byte = device_addr;
            tfr_pkg::PosAckId:   word_byte = check_frame_id;
            tfr_pkg::PosAckLen:  word_byte = tfr_pkg::AckLen;
            tfr_pkg::PosAckFid:  word_byte = head_cmd.fid;
            tfr_pkg::PosAckRsum: word_byte = head_cmd.rsum;
            tfr_pkg::PosAckRadd: word_byte = head_cmd.radd;
            tfr_pkg::PosRepSync: word_byte = tfr_pkg::SyncByte;
            tfr_pkg::PosRepAddr: word_byte = host_addr;
            tfr_pkg::PosRepId:   word_byte = tfr_pkg::IdE2;
            tfr_pkg::PosRepLen:  word_byte = tfr_pkg::ReplyLen;
            tfr_pkg::PosRepDev:  word_byte = device_addr;
            tfr_pkg::PosRepZero: word_byte = tfr_pkg::ZeroByte;
            tfr_pkg::PosAckSum, tfr_pkg::PosRepSum:
            begin
                word_byte = s_reg;
                data_pos  = 1'b0;
            end
            tfr_pkg::PosAckAdd, tfr_pkg::PosRepAdd:
            begin
                word_byte = a_reg;
                data_pos  = 1'b0;
            end
            default:
            begin
                word_byte = tfr_pkg::ZeroByte;
                data_pos  = 1'b0;
            end
        endcase
    end

    assign frame_start = (pos_reg == tfr_pkg::PosAckSync) || (pos_reg == tfr_pkg::PosRepSync);
    assign s_new = (frame_start ? 8'd0 : s_reg) + word_byte;
    assign a_new = (frame_start ? 8'd0 : a_reg) + s_new;

    always_comb
    begin
        if (!head_cmd.ok)
        begin
            word_last = 1'b1;
        end
        else if (pos_reg == tfr_pkg::PosAckAdd)
        begin
            word_last = !head_cmd.e1;
        end
        else
        begin
            word_last = (pos_reg == tfr_pkg::PosRepAdd);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        s_next   = s_reg;
        a_next   = a_reg;
        if (load)
        begin
            pos_next = word_last ? tfr_pkg::PosAckSync : pos_reg + 1'b1;
            if (head_cmd.ok && data_pos)
            begin
                s_next = s_new;
                a_next = a_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= tfr_pkg::PosAckSync;
            s_reg     <= 8'd0;
            a_reg     <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            s_reg   <= s_next;
            a_reg   <= a_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg  <= head_cmd.err;
            ok_reg   <= head_cmd.ok;
            txv_reg  <= head_cmd.ok;
            txb_reg  <= head_cmd.ok ? word_byte : tfr_pkg::ZeroByte;
            last_reg <= word_last;
        end
    end

    assign out_valid    = valid_reg;
    assign out_rx_error = err_reg;
    assign out_frame_ok = ok_reg;
    assign out_tx_valid = txv_reg;
    assign out_tx_byte  = txb_reg;
    assign out_last     = last_reg;

    `ASSERT_ALWAYS(a_pos_range, pos_reg <= tfr_pkg::PosRepAdd, "reply position out of range")
    `ASSERT_IMPLIES(a_mid_reply_head, pos_reg != tfr_pkg::PosAckSync, head_valid && head_cmd.ok, "reply in progress without a good frame at head")
    `ASSERT_IMPLIES(a_e2_only_e1, pos_reg > tfr_pkg::PosAckAdd, head_cmd.e1, "host reply for a frame other than E1")

endmodule

FILE: design/telemetry_frame_receiver_core.sv
`timescale 1ns / 1ps
// Telemetry frame receiver. One received byte per input word. The parser takes a
// byte every cycle while its two-entry command queue has room; each byte yields one
// result word, or 9 words for a good frame (17 for id E1), which the reply
// generator sends one per cycle from its output register while the result channel
// is ready, so the sustained rate is set by the reply generator.
// Depends on tfr_pkg, tfr_front, tfr_queue, tfr_back and the three channel interfaces.
module telemetry_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    tfr_in_if.sink      byte_ch,
    tfr_out_if.source   result_ch,
    tfr_cfg_if.sink     cfg
);

    logic [7:0] device_addr_reg;
    logic [7:0] host_addr_reg;
    logic [7:0] check_frame_id_reg;

    logic          q_full;
    logic          push;
    tfr_pkg::cmd_t push_cmd;
    logic          pop;
    logic          head_valid;
    tfr_pkg::cmd_t head_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_addr_reg    <= tfr_pkg::DevAddrReset;
            host_addr_reg      <= tfr_pkg::HostAddrReset;
            check_frame_id_reg <= tfr_pkg::AckIdReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tfr_pkg::CfgDeviceAddr:   device_addr_reg    <= cfg.data;
                tfr_pkg::CfgHostAddr:     host_addr_reg      <= cfg.data;
                tfr_pkg::CfgCheckFrameId: check_frame_id_reg <= cfg.data;
                default:                  ;
            endcase
        end
    end

    tfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (byte_ch.valid),
        .in_byte     (byte_ch.rx_byte),
        .in_ready    (byte_ch.ready),
        .device_addr (device_addr_reg),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    tfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .device_addr    (device_addr_reg),
        .host_addr      (host_addr_reg),
        .check_frame_id (check_frame_id_reg),
        .out_valid      (result_ch.valid),
        .out_ready      (result_ch.ready),
        .out_rx_error   (result_ch.rx_error),
        .out_frame_ok   (result_ch.frame_ok),
        .out_tx_valid   (result_ch.tx_valid),
        .out_tx_byte    (result_ch.tx_byte),
        .out_last       (result_ch.last)
    );

endmodule
